@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the datapath module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in one cycle implies consequent in the next cycle.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Expression never holds.
`define AST_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: forbidden condition");

`endif

@@ hw/rtl/flmgd_pkg.sv @@
// Package: constants, tables and controller/datapath interface types.
`default_nettype none
package flmgd_pkg;
    localparam int MAX_BINS_DEF     = 4096;
    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int IDX_W   = 12;
    localparam int LEVEL_W = 25;
    localparam int GD_W    = 16;
    localparam int OUT_W   = 56;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_LOG   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_MUL   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_ADD   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP_DLY  = 8'd3;

    localparam int NORM_W     = 64;
    localparam int NORM_STEPS = 6;
    localparam int FRAC_STEPS = 16;
    localparam int LQ_W       = 22;

    localparam logic [30:0]        LOG10_2_Q32 = 31'd1292913986;
    localparam logic [LEVEL_W-1:0] LOG_OFFSET  = 25'd4932;
    localparam logic [LEVEL_W-1:0] LOG_ZERO    = 25'h1000000;
    localparam logic [LEVEL_W-1:0] LIN_MAX     = 25'hFFFFFF;

    function automatic logic [31:0] atan_angle(input logic [4:0] i);
        case (i)
            5'd0:  atan_angle = 32'd536870912;
            5'd1:  atan_angle = 32'd316933406;
            5'd2:  atan_angle = 32'd167458907;
            5'd3:  atan_angle = 32'd85004756;
            5'd4:  atan_angle = 32'd42667331;
            5'd5:  atan_angle = 32'd21354465;
            5'd6:  atan_angle = 32'd10679838;
            5'd7:  atan_angle = 32'd5340245;
            5'd8:  atan_angle = 32'd2670163;
            5'd9:  atan_angle = 32'd1335087;
            5'd10: atan_angle = 32'd667544;
            5'd11: atan_angle = 32'd333772;
            5'd12: atan_angle = 32'd166886;
            5'd13: atan_angle = 32'd83443;
            5'd14: atan_angle = 32'd41722;
            5'd15: atan_angle = 32'd20861;
            5'd16: atan_angle = 32'd10430;
            5'd17: atan_angle = 32'd5215;
            5'd18: atan_angle = 32'd2608;
            5'd19: atan_angle = 32'd1304;
            5'd20: atan_angle = 32'd652;
            5'd21: atan_angle = 32'd326;
            5'd22: atan_angle = 32'd163;
            5'd23: atan_angle = 32'd81;
            default: atan_angle = 32'd0;
        endcase
    endfunction

    typedef struct packed {
        logic capture;
        logic square;
        logic start;
        logic iter_en;
        logic load_v;
        logic norm_en;
        logic lsq_en;
        logic lconv;
        logic lfin;
        logic load_prior;
        logic load_last;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic iter_done;
        logic norm_done;
        logic lsq_done;
        logic have_prior;
        logic last;
        logic slot_free;
    } t_status;
endpackage
`default_nettype wire

@@ hw/rtl/flmgd_ctrl.sv @@
// Controller: sequences the per-bin computation and result transfers.
`default_nettype none
module flmgd_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire flmgd_pkg::t_status i_status,
    output flmgd_pkg::t_cmd        o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_SUM   = 4'd2;
    localparam logic [3:0] S_ITER  = 4'd3;
    localparam logic [3:0] S_LMUL  = 4'd4;
    localparam logic [3:0] S_NORM  = 4'd5;
    localparam logic [3:0] S_LSQ   = 4'd6;
    localparam logic [3:0] S_LCONV = 4'd7;
    localparam logic [3:0] S_LFIN  = 4'd8;
    localparam logic [3:0] S_EMITP = 4'd9;
    localparam logic [3:0] S_EMITL = 4'd10;

    logic [3:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.square = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.start = 1'b1;
                n_state = S_ITER;
            end
            S_ITER: begin
                if (i_status.iter_done) n_state = S_LMUL;
                else o_cmd.iter_en = 1'b1;
            end
            S_LMUL: begin
                o_cmd.load_v = 1'b1;
                n_state = S_NORM;
            end
            S_NORM: begin
                if (i_status.norm_done) n_state = S_LSQ;
                else o_cmd.norm_en = 1'b1;
            end
            S_LSQ: begin
                if (i_status.lsq_done) n_state = S_LCONV;
                else o_cmd.lsq_en = 1'b1;
            end
            S_LCONV: begin
                o_cmd.lconv = 1'b1;
                n_state = S_LFIN;
            end
            S_LFIN: begin
                o_cmd.lfin = 1'b1;
                n_state = S_EMITP;
            end
            S_EMITP: begin
                if (!i_status.have_prior || i_status.slot_free) begin
                    o_cmd.load_prior = i_status.have_prior;
                    if (i_status.last) begin
                        n_state = S_EMITL;
                    end else begin
                        o_cmd.commit = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMITL: begin
                if (i_status.slot_free) begin
                    o_cmd.load_last = 1'b1;
                    o_cmd.commit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end
endmodule
`default_nettype wire

@@ hw/rtl/flmgd_dp.sv @@
// Datapath: magnitude, CORDIC phase, log level, frame state and output register.
`default_nettype none
`include "assert_macros.svh"
module flmgd_dp #(
    parameter int MAX_BINS     = flmgd_pkg::MAX_BINS_DEF,
    parameter int SAMPLE_BITS  = flmgd_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = flmgd_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [2*SAMPLE_BITS-1:0]     i_in_data,
    input  wire logic                         i_in_last,
    input  wire logic                         i_cfg_valid,
    input  wire logic [flmgd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [flmgd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire flmgd_pkg::t_cmd              i_cmd,
    output flmgd_pkg::t_status                o_status,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic [flmgd_pkg::OUT_W-1:0]       o_out_data,
    output logic                              o_out_last
);
    localparam int SB    = SAMPLE_BITS;
    localparam int CW    = SB + 19;
    localparam int SQC_W = $clog2(SB + 1);
    localparam int IW    = flmgd_pkg::IDX_W;
    localparam int LW    = flmgd_pkg::LEVEL_W;
    localparam int GW    = flmgd_pkg::GD_W;
    localparam int VW    = flmgd_pkg::NORM_W;

    // configuration
    logic        r_use_log, r_comp_dly;
    logic [15:0] r_log_mul, r_log_add;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_log  <= 1'b1;
            r_log_mul  <= 16'd256;
            r_log_add  <= 16'd256;
            r_comp_dly <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                flmgd_pkg::CFG_USE_LOG:  r_use_log  <= i_cfg_data[0];
                flmgd_pkg::CFG_LOG_MUL:  r_log_mul  <= i_cfg_data;
                flmgd_pkg::CFG_LOG_ADD:  r_log_add  <= i_cfg_data;
                flmgd_pkg::CFG_COMP_DLY: r_comp_dly <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input capture and squares
    logic signed [SB-1:0] r_re, r_im;
    logic                 r_last;
    logic [SB-1:0]        abs_re, abs_im;
    logic [2*SB-1:0]      r_sq_re, r_sq_im, r_s;

    assign abs_re = r_re[SB-1] ? (~r_re + 1'b1) : r_re;
    assign abs_im = r_im[SB-1] ? (~r_im + 1'b1) : r_im;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_re   <= i_in_data[SB-1:0];
            r_im   <= i_in_data[2*SB-1:SB];
            r_last <= i_in_last;
        end
        if (i_cmd.square) begin
            r_sq_re <= abs_re * abs_re;
            r_sq_im <= abs_im * abs_im;
        end
    end

    // integer square root, one result bit per cycle
    logic [SB:0]      r_rem;
    logic [SB-1:0]    r_root;
    logic [SQC_W-1:0] r_sq_cnt;
    logic [SB+2:0]    rem_sh, trial, rem_diff;
    logic             sq_done;

    assign sq_done  = (r_sq_cnt == SQC_W'(SB));
    assign rem_sh   = {r_rem, r_s[2*SB-1:2*SB-2]};
    assign trial    = {1'b0, r_root, 2'b01};
    assign rem_diff = rem_sh - trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_s      <= r_sq_re + r_sq_im;
            r_rem    <= '0;
            r_root   <= '0;
            r_sq_cnt <= '0;
        end else if (i_cmd.iter_en && !sq_done) begin
            r_s      <= {r_s[2*SB-3:0], 2'b00};
            r_sq_cnt <= r_sq_cnt + 1'b1;
            if (rem_sh >= trial) begin
                r_rem  <= rem_diff[SB:0];
                r_root <= {r_root[SB-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[SB:0];
                r_root <= {r_root[SB-2:0], 1'b0};
            end
        end
    end

    // CORDIC vectoring for the phase
    logic signed [CW-1:0] r_x, r_y, x0, y0, tx, ty;
    logic [31:0]          r_z;
    logic [4:0]           r_cd_cnt;
    logic                 r_zero, cd_done;

    assign x0      = CW'(r_re) <<< 16;
    assign y0      = CW'(r_im) <<< 16;
    assign tx      = r_x >>> r_cd_cnt;
    assign ty      = r_y >>> r_cd_cnt;
    assign cd_done = (r_cd_cnt == 5'(CORDIC_STEPS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cd_cnt <= '0;
            r_zero   <= (r_re == '0) && (r_im == '0);
            if (r_re[SB-1]) begin
                r_x <= -x0;
                r_y <= -y0;
                r_z <= 32'h8000_0000;
            end else begin
                r_x <= x0;
                r_y <= y0;
                r_z <= 32'h0;
            end
        end else if (i_cmd.iter_en && !cd_done) begin
            r_cd_cnt <= r_cd_cnt + 1'b1;
            if (!r_y[CW-1]) begin
                r_x <= r_x + ty;
                r_y <= r_y - tx;
                r_z <= r_z + flmgd_pkg::atan_angle(r_cd_cnt);
            end else begin
                r_x <= r_x - ty;
                r_y <= r_y + tx;
                r_z <= r_z - flmgd_pkg::atan_angle(r_cd_cnt);
            end
        end
    end

    // log10 of scaled magnitude
    logic [VW-1:0]  r_v, top_mask;
    logic           r_v_zero, top_zero;
    logic [5:0]     r_p, sh;
    logic [2:0]     r_ncnt;
    logic [30:0]    r_m;
    logic [61:0]    m_sq;
    logic [flmgd_pkg::LQ_W-1:0] r_lq;
    logic [4:0]     r_lcnt;
    logic [15:0]    r_conv;
    logic [53:0]    conv_sum;
    logic           norm_done, lsq_done;

    assign sh        = 6'(7'd32 >> r_ncnt);
    assign top_mask  = ~({VW{1'b1}} >> sh);
    assign top_zero  = ((r_v & top_mask) == '0);
    assign norm_done = (r_ncnt == 3'(flmgd_pkg::NORM_STEPS));
    assign lsq_done  = (r_lcnt == 5'(flmgd_pkg::FRAC_STEPS));
    assign m_sq      = r_m * r_m;
    assign conv_sum  = 54'(r_lq * flmgd_pkg::LOG10_2_Q32) + (54'd1 << 36);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_v) begin
            r_v      <= VW'(r_log_mul * r_root) + VW'(r_log_add);
            r_v_zero <= ((r_log_mul == '0) || (r_root == '0)) && (r_log_add == '0);
            r_p      <= 6'd63;
            r_ncnt   <= '0;
            r_lcnt   <= '0;
        end else if (i_cmd.norm_en && !norm_done) begin
            r_ncnt <= r_ncnt + 1'b1;
            if (top_zero) begin
                r_v <= r_v << sh;
                r_p <= r_p - sh;
            end
            if (r_ncnt == 3'(flmgd_pkg::NORM_STEPS - 1)) begin
                r_lq <= {r_p - (top_zero ? sh : 6'd0), 16'd0};
                r_m  <= top_zero ? 31'((r_v << sh) >> 33) : r_v[VW-1:33];
            end
        end else if (i_cmd.lsq_en && !lsq_done) begin
            r_lcnt <= r_lcnt + 1'b1;
            if (m_sq[61]) begin
                r_m  <= m_sq[61:31];
                r_lq <= r_lq | (flmgd_pkg::LQ_W'(1) << (5'd15 - r_lcnt));
            end else begin
                r_m  <= m_sq[60:30];
            end
        end
        if (i_cmd.lconv) r_conv <= conv_sum[52:37];
    end

    // level and phase of the current bin
    logic [LW-1:0] r_level, lin_level;
    logic [15:0]   r_phase;
    logic [32:0]   mag_ext;
    logic [31:0]   z_rnd;

    assign mag_ext   = 33'(r_root);
    assign lin_level = (mag_ext > 33'(flmgd_pkg::LIN_MAX)) ? flmgd_pkg::LIN_MAX
                                                            : mag_ext[LW-1:0];
    assign z_rnd     = r_z + 32'h8000;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lfin) begin
            r_phase <= r_zero ? 16'd0 : z_rnd[31:16];
            if (!r_use_log) r_level <= lin_level;
            else if (r_v_zero) r_level <= flmgd_pkg::LOG_ZERO;
            else r_level <= LW'(r_conv) - flmgd_pkg::LOG_OFFSET;
        end
    end

    // frame state
    logic          r_have_prior;
    logic [IW-1:0] r_bin_cnt, prior_idx;
    logic [LW-1:0] r_prior_level;
    logic [15:0]   r_prior_phase;

    assign prior_idx = (r_bin_cnt == '0) ? IW'(MAX_BINS - 1) : r_bin_cnt - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prior <= 1'b0;
            r_bin_cnt    <= '0;
        end else if (i_cmd.commit) begin
            if (r_last) begin
                r_have_prior <= 1'b0;
                r_bin_cnt    <= '0;
            end else begin
                r_have_prior <= 1'b1;
                r_bin_cnt    <= (r_bin_cnt == IW'(MAX_BINS - 1)) ? '0 : r_bin_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && !r_last) begin
            r_prior_level <= r_level;
            r_prior_phase <= r_phase;
        end
    end

    // output register
    logic          r_o_valid, r_o_end, slot_free;
    logic [IW-1:0] r_o_idx;
    logic [LW-1:0] r_o_level;
    logic [GW-1:0] r_o_gd;

    assign slot_free = !r_o_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_valid <= 1'b0;
        else if (i_cmd.load_prior || i_cmd.load_last) r_o_valid <= 1'b1;
        else if (i_out_ready) r_o_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_prior) begin
            r_o_idx   <= prior_idx;
            r_o_level <= r_prior_level;
            r_o_gd    <= r_comp_dly ? (r_prior_phase - r_phase) : '0;
            r_o_end   <= 1'b0;
        end else if (i_cmd.load_last) begin
            r_o_idx   <= r_bin_cnt;
            r_o_level <= r_level;
            r_o_gd    <= '0;
            r_o_end   <= 1'b1;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_last  = r_o_end;
    assign o_out_data  = {3'b000, r_o_gd, r_o_level, r_o_idx};

    assign o_status.iter_done  = sq_done && cd_done;
    assign o_status.norm_done  = norm_done;
    assign o_status.lsq_done   = lsq_done;
    assign o_status.have_prior = r_have_prior;
    assign o_status.last       = r_last;
    assign o_status.slot_free  = slot_free;

    `AST_NEXT(a_last_clears, i_clk, i_rst_n, i_cmd.load_last, !r_have_prior && r_bin_cnt == '0)
    `AST_NEXT(a_prior_set, i_clk, i_rst_n, i_cmd.commit && !r_last, r_have_prior)
    `AST_NEVER(a_cnt_range, i_clk, i_rst_n, r_bin_cnt > IW'(MAX_BINS - 1))
endmodule
`default_nettype wire

@@ hw/rtl/fft_bin_log_magnitude_group_delay_core.sv @@
// Top level: FFT bin level and local group delay core.
// Input stream: one FFT bin per transfer, tdata = real (low) and imag,
// tlast marks the last bin of a frame. Output stream: one result per
// transfer, tdata = bin_index, level, group_delay (low to high), tlast set
// on the result of the frame's last bin. Each result is issued one bin late;
// the last bin issues the pending result and then its own.
// One bin is processed at a time; the next bin is taken only once the
// current one is finished and any result it issues is in the output
// register. Each bin runs the bit-serial square root and CORDIC loop,
// then the sixteen squaring steps of the log unit; a last bin issues a
// second result for itself, after the pending one.
// The config channel is always ready; write it only while the core is idle.
// Reset clears the frame state and loads register defaults (log on, mul and
// add 1.0, delay off). When the receiver stalls, the finished result holds
// in the output register and the core stalls before issuing the next one.
`default_nettype none
module fft_bin_log_magnitude_group_delay_core #(
    parameter int MAX_BINS     = flmgd_pkg::MAX_BINS_DEF,
    parameter int SAMPLE_BITS  = flmgd_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = flmgd_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_axis_tvalid,
    output logic      o_s_axis_tready,
    // bin_real, bin_imag, zero fill
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    input  wire logic i_s_axis_tlast,
    output logic      o_m_axis_tvalid,
    input  wire logic i_m_axis_tready,
    // bin_index, level, group_delay, zero fill
    output logic [flmgd_pkg::OUT_W-1:0] o_m_axis_tdata,
    output logic      o_m_axis_tlast,
    input  wire logic i_cfg_valid,
    output logic      o_cfg_ready,
    input  wire logic [flmgd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [flmgd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    flmgd_pkg::t_cmd    cmd;
    flmgd_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    flmgd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    flmgd_dp #(
        .MAX_BINS     (MAX_BINS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_s_axis_tdata[2*SAMPLE_BITS-1:0]),
        .i_in_last   (i_s_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Testbench for the FFT bin level and group delay core: stream stimulus with self-checking.
`timescale 1ns / 1ps
module testbench;
    localparam int SBITS = 24;
    localparam int IDX_W = flmgd_pkg::IDX_W;
    localparam int LEVEL_W = flmgd_pkg::LEVEL_W;
    localparam int GD_W = flmgd_pkg::GD_W;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 64;
    localparam int LVL_LO = IDX_W;
    localparam int GD_LO = IDX_W + LEVEL_W;

    typedef struct packed {
        logic [IDX_W-1:0]   bin_index;
        logic [LEVEL_W-1:0] level;
        logic [GD_W-1:0]    group_delay;
        logic               frame_end;
    } bin_result_t;

    logic i_clk;
    logic i_rst_n;
    logic i_s_axis_tvalid;
    logic o_s_axis_tready;
    logic [2*SBITS-1:0] i_s_axis_tdata;
    logic i_s_axis_tlast;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready;
    logic [flmgd_pkg::OUT_W-1:0] o_m_axis_tdata;
    logic o_m_axis_tlast;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [flmgd_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [flmgd_pkg::CFG_DATA_W-1:0] i_cfg_data;

    fft_bin_log_magnitude_group_delay_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // shadow registers and frame state of the predictor
    logic        sh_use_log;
    logic [15:0] sh_log_mul;
    logic [15:0] sh_log_add;
    logic        sh_comp_dly;
    logic [15:0]        prev_phase;
    logic [LEVEL_W-1:0] prev_level;
    logic               pending;
    logic [IDX_W-1:0]   next_index;

    bin_result_t expected_results[$];
    int error_count;
    int cycle_count;
    int burst_left;
    bit long_hold_req;

    localparam logic [31:0] ATAN_Q31 [16] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
        32'd166886, 32'd83443, 32'd41722, 32'd20861
    };

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fft_bin_log_magnitude_group_delay_core: mismatch");
            $finish;
        end
    end

    function automatic longint unsigned floor_sqrt(input longint unsigned s);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [LEVEL_W-1:0] log10_q411(input longint unsigned mag);
        longint unsigned v;
        longint unsigned m;
        longint unsigned lq;
        longint signed lvl;
        int p;
        v = longint'(sh_log_mul) * mag + longint'(sh_log_add);
        if (v == 0) return flmgd_pkg::LOG_ZERO;
        p = 0;
        while (p < 63 && (v >> (p + 1)) != 0) p++;
        m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
        lq = longint'(p) << 16;
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                lq = lq | (64'd1 << (15 - k));
            end
        end
        lvl = longint'((lq * 64'd1292913986 + (64'd1 << 36)) >> 37) - 4932;
        return lvl[LEVEL_W-1:0];
    endfunction

    function automatic logic [15:0] cordic_phase(input longint signed re, input longint signed im);
        longint signed x;
        longint signed y;
        longint signed tx;
        longint signed ty;
        logic [31:0] z;
        if (re == 0 && im == 0) return 16'd0;
        x = re * 65536;
        y = im * 65536;
        z = 32'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < 16; i++) begin
            tx = x >>> i;
            ty = y >>> i;
            if (y >= 0) begin
                x = x + ty;
                y = y - tx;
                z = z + ATAN_Q31[i];
            end else begin
                x = x - ty;
                y = y + tx;
                z = z - ATAN_Q31[i];
            end
        end
        z = z + 32'h8000;
        return z[31:16];
    endfunction

    function automatic void predict_bin(input logic signed [SBITS-1:0] re,
                                        input logic signed [SBITS-1:0] im,
                                        input logic last);
        longint signed sre;
        longint signed sim;
        longint unsigned mag;
        logic [LEVEL_W-1:0] lvl;
        logic [15:0] ph;
        bin_result_t r;
        sre = re;
        sim = im;
        mag = floor_sqrt(longint'(sre * sre) + longint'(sim * sim));
        if (sh_use_log) lvl = log10_q411(mag);
        else lvl = (mag > 64'd16777215) ? flmgd_pkg::LIN_MAX : mag[LEVEL_W-1:0];
        ph = cordic_phase(sre, sim);
        if (pending) begin
            r.bin_index = next_index - 1'b1;
            r.level = prev_level;
            r.group_delay = sh_comp_dly ? (prev_phase - ph) : 16'd0;
            r.frame_end = 1'b0;
            expected_results.push_back(r);
        end
        if (last) begin
            r.bin_index = next_index;
            r.level = lvl;
            r.group_delay = 16'd0;
            r.frame_end = 1'b1;
            expected_results.push_back(r);
            pending = 1'b0;
            next_index = '0;
        end else begin
            prev_level = lvl;
            prev_phase = ph;
            pending = 1'b1;
            next_index = next_index + 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        bin_result_t got;
        bin_result_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.bin_index = o_m_axis_tdata[IDX_W-1:0];
            got.level = o_m_axis_tdata[LVL_LO +: LEVEL_W];
            got.group_delay = o_m_axis_tdata[GD_LO +: GD_W];
            got.frame_end = o_m_axis_tlast;
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer: %p", got);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.bin_index !== want.bin_index) begin
                    $error("bin_index: expected %0d, got %0d", want.bin_index, got.bin_index);
                    error_count++;
                end
                if (got.level !== want.level) begin
                    $error("level: expected %0d, got %0d",
                           $signed(want.level), $signed(got.level));
                    error_count++;
                end
                if (got.group_delay !== want.group_delay) begin
                    $error("group_delay: expected %0d, got %0d",
                           $signed(want.group_delay), $signed(got.group_delay));
                    error_count++;
                end
                if (got.frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
                    error_count++;
                end
            end
        end
    end

    // receiver stall pattern, with a long hold on request
    initial begin
        int mode;
        i_m_axis_tready = 1'b0;
        forever begin
            if (long_hold_req) begin
                @(posedge i_clk);
                i_m_axis_tready <= 1'b0;
                repeat (700) @(posedge i_clk);
                long_hold_req = 1'b0;
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 300)) begin
                @(posedge i_clk);
                case (mode)
                    0: i_m_axis_tready <= 1'b1;
                    1: i_m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2: i_m_axis_tready <= ($urandom_range(0, 7) == 0);
                    default: i_m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic send_bin(input logic signed [SBITS-1:0] re,
                            input logic signed [SBITS-1:0] im, input logic last);
        i_s_axis_tdata <= {im, re};
        i_s_axis_tlast <= last;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_bin(re, im, last);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 70)) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [flmgd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            flmgd_pkg::CFG_USE_LOG:  sh_use_log = val[0];
            flmgd_pkg::CFG_LOG_MUL:  sh_log_mul = val;
            flmgd_pkg::CFG_LOG_ADD:  sh_log_add = val;
            flmgd_pkg::CFG_COMP_DLY: sh_comp_dly = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_mode(input logic use_log, input logic [15:0] mul,
                            input logic [15:0] add, input logic dly);
        wait_idle();
        write_reg(flmgd_pkg::CFG_USE_LOG, {15'd0, use_log});
        write_reg(flmgd_pkg::CFG_LOG_MUL, mul);
        write_reg(flmgd_pkg::CFG_LOG_ADD, add);
        write_reg(flmgd_pkg::CFG_COMP_DLY, {15'd0, dly});
    endtask

    function automatic logic [SBITS-1:0] rand_sample();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 5))
            0: return {r[23] ? 1'b1 : 1'b0, r[22:0]};
            1: return $signed(r[5:0]) - 6'sd0;
            2: return r[0] ? 24'h7FFFFF : 24'h800000;
            3: return 24'd0;
            4: return $signed(r[23:0]) >>> $urandom_range(0, 22);
            default: return r[23:0];
        endcase
    endfunction

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++) send_bin(rand_sample(), rand_sample(), i == len - 1);
    endtask

    task automatic test_extremes();
        set_mode(1'b1, 16'd256, 16'd256, 1'b1);
        send_bin(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
        send_bin(-24'sh800000, -24'sh800000, 1'b0);
        send_bin(-24'sh800000, 24'sh7FFFFF, 1'b0);
        send_bin(24'sd0, 24'sd0, 1'b0);
        send_bin(24'sh7FFFFF, 24'sd0, 1'b0);
        send_bin(24'sd0, -24'sh800000, 1'b0);
        send_bin(-24'sd1, 24'sd0, 1'b0);
        send_bin(24'sd1, -24'sd1, 1'b0);
        send_bin(-24'sd5, -24'sd3, 1'b1);
        send_bin(24'sd100, -24'sd7, 1'b1);
        set_mode(1'b0, 16'd1, 16'd1, 1'b0);
        send_bin(24'sh7FFFFF, -24'sh800000, 1'b0);
        send_bin(-24'sh800000, 24'sd0, 1'b0);
        send_bin(24'sd3, 24'sd4, 1'b1);
    endtask

    task automatic test_log_of_zero();
        set_mode(1'b1, 16'd256, 16'd0, 1'b1);
        send_bin(24'sd0, 24'sd0, 1'b0);
        send_bin(24'sd0, 24'sd0, 1'b1);
    endtask

    task automatic test_ignored_index();
        wait_idle();
        write_reg(8'd4, 16'hFFFF);
        write_reg(8'd255, 16'h0000);
        send_frame(5);
    endtask

    task automatic test_config_extremes();
        set_mode(1'b1, 16'd65535, 16'd65535, 1'b1);
        send_frame(6);
        set_mode(1'b1, 16'd1, 16'd1, 1'b0);
        send_frame(6);
        set_mode(1'b0, 16'd65535, 16'd1, 1'b1);
        send_frame(6);
    endtask

    task automatic test_input_stall();
        set_mode(1'b1, 16'd512, 16'd128, 1'b1);
        long_hold_req = 1'b1;
        for (int i = 0; i < 24; i++) send_bin(rand_sample(), rand_sample(), i == 23);
    endtask

    task automatic test_random_frames();
        int sent;
        int len;
        sent = 0;
        while (sent < 1870) begin
            if ($urandom_range(0, 9) == 0)
                set_mode(1'($urandom_range(0, 1)), 16'($urandom_range(1, 65535)),
                         16'($urandom_range(1, 65535)), 1'($urandom_range(0, 1)));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 200) : $urandom_range(1, 40);
            send_frame(len);
            sent += len;
        end
        // an open frame at the end, then its last bin
        send_frame(3);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tlast = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        burst_left = 8;
        long_hold_req = 1'b0;
        sh_use_log = 1'b1;
        sh_log_mul = 16'd256;
        sh_log_add = 16'd256;
        sh_comp_dly = 1'b0;
        prev_phase = '0;
        prev_level = '0;
        pending = 1'b0;
        next_index = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default registers first
        send_frame(4);
        test_extremes();
        test_log_of_zero();
        test_ignored_index();
        test_config_extremes();
        test_input_stall();
        test_random_frames();

        wait_idle();
        if (error_count == 0)
            $display("fft_bin_log_magnitude_group_delay_core: match");
        else
            $display("fft_bin_log_magnitude_group_delay_core: mismatch");
        $finish;
    end
endmodule

@@ fft_bin_log_magnitude_group_delay_core.f @@
+incdir+hw/rtl
hw/rtl/flmgd_pkg.sv
hw/rtl/flmgd_ctrl.sv
hw/rtl/flmgd_dp.sv
hw/rtl/fft_bin_log_magnitude_group_delay_core.sv
bench/testbench.sv
